// File: rtl/core/vn_pkg.sv
// ---------------------------------------------------------------------------
// vn_pkg
// Shared constants and types for the 3d vector normalizer.
// ---------------------------------------------------------------------------
package vn_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_IN_WIDTH  = 32;
  localparam int CFG_W         = 16;
  localparam int NUM_COMP      = 3;

  typedef logic [CFG_W-1:0] min_len_t;

endpackage

// File: rtl/core/vector3_normalize.sv
// ---------------------------------------------------------------------------
// vector3_normalize
// Pipelined 3d vector normalizer: squares, sum, square root cells, divide cells.
// ---------------------------------------------------------------------------
// pipeline: the strobe follows the start transfer through the stage 0, squares,
//   sum, square root, divide setup, divide and output registers, with one square
//   root cell per root bit and one divide cell per quotient bit
// throughput: one vector every cycle, busy is never raised
// reset: rst_n clears the pipeline valid bits and min_length to 0
module vector3_normalize #(
  parameter int FRAC_BITS = vn_pkg::DEF_FRAC_BITS,
  parameter int IN_WIDTH  = vn_pkg::DEF_IN_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [IN_WIDTH-1:0]  in_comp_x,
  input  logic signed [IN_WIDTH-1:0]  in_comp_y,
  input  logic signed [IN_WIDTH-1:0]  in_comp_z,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  vn_pkg::min_len_t            cfg_data,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] out_unit_x,
  output logic signed [FRAC_BITS+1:0] out_unit_y,
  output logic signed [FRAC_BITS+1:0] out_unit_z,
  output logic                        out_ok
);
  import vn_pkg::*;

  localparam int W  = IN_WIDTH;
  localparam int SW = 2 * IN_WIDTH;
  localparam int DW = IN_WIDTH + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;
  localparam int OW = FRAC_BITS + 2;
  localparam int ND = FRAC_BITS + 1;
  localparam int CW = (IN_WIDTH > CFG_W) ? IN_WIDTH : CFG_W;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  min_len_t min_len_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_len_r <= cfg_data;
    end
  end

  // stage 0: magnitude and sign
  logic [W-1:0] comp_raw [NUM_COMP];
  logic         vld0_r;
  logic [W-1:0] mag0_r [NUM_COMP];
  logic         neg0_r [NUM_COMP];

  assign comp_raw[0] = in_comp_x;
  assign comp_raw[1] = in_comp_y;
  assign comp_raw[2] = in_comp_z;

  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else        vld0_r <= start && !busy;
  end

  // stage 1: squares
  logic          vld1_r;
  logic [SW-1:0] sq1_r [NUM_COMP];
  logic [W-1:0]  mag1_r [NUM_COMP];
  logic          neg1_r [NUM_COMP];

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else        vld1_r <= vld0_r;
  end

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_front
    always_ff @(posedge clk) begin
      neg0_r[c] <= comp_raw[c][W-1];
      mag0_r[c] <= comp_raw[c][W-1] ? (~comp_raw[c] + W'(1)) : comp_raw[c];
      sq1_r[c]  <= SW'(mag0_r[c]) * SW'(mag0_r[c]);
      mag1_r[c] <= mag0_r[c];
      neg1_r[c] <= neg0_r[c];
    end
  end

  // square root chain, index 0 holds the sum
  logic [SW-1:0] rad_c  [W+1];
  logic [W:0]    rem_c  [W+1];
  logic [W-1:0]  root_c [W+1];
  logic          vld_c_r [W+1];
  logic [W-1:0]  mag_c_r [W+1][NUM_COMP];
  logic          neg_c_r [W+1][NUM_COMP];
  logic [SW-1:0] sum_r;

  always_ff @(posedge clk) begin
    // three squares of the magnitudes never pass 2^(2*IN_WIDTH)
    sum_r <= sq1_r[0] + sq1_r[1] + sq1_r[2];
  end
  assign rad_c[0]  = sum_r;
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_c_r[0] <= 1'b0;
    else        vld_c_r[0] <= vld1_r;
  end
  for (genvar c = 0; c < NUM_COMP; c++) begin : g_side0
    always_ff @(posedge clk) begin
      mag_c_r[0][c] <= mag1_r[c];
      neg_c_r[0][c] <= neg1_r[c];
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    vn_sqrt_cell #(.IN_WIDTH(IN_WIDTH)) u_cell (
      .clk    (clk),
      .rad_i  (rad_c[k]),
      .rem_i  (rem_c[k]),
      .root_i (root_c[k]),
      .rad_o  (rad_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .root_o (root_c[k+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) vld_c_r[k+1] <= 1'b0;
      else        vld_c_r[k+1] <= vld_c_r[k];
    end
    for (genvar c = 0; c < NUM_COMP; c++) begin : g_side
      always_ff @(posedge clk) begin
        mag_c_r[k+1][c] <= mag_c_r[k][c];
        neg_c_r[k+1][c] <= neg_c_r[k][c];
      end
    end
  end

  // threshold compare and divide setup, then one divide cell per quotient bit
  logic          vld_d_r [ND+1];
  logic [W-1:0]  len_d_r [ND+1];
  logic          ok_d_r  [ND+1];
  logic          neg_d_r [ND+1][NUM_COMP];
  logic [DW-1:0] rem_d   [ND+1][NUM_COMP];
  logic [QW-1:0] q_d     [ND+1][NUM_COMP];
  logic [DW-1:0] dvd0_r  [NUM_COMP];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_d_r[0] <= 1'b0;
    else        vld_d_r[0] <= vld_c_r[W];
    len_d_r[0] <= root_c[W];
    ok_d_r[0]  <= (CW'(root_c[W]) > CW'(min_len_r));
  end
  for (genvar c = 0; c < NUM_COMP; c++) begin : g_dset
    always_ff @(posedge clk) begin
      neg_d_r[0][c] <= neg_c_r[W][c];
      dvd0_r[c]     <= DW'(mag_c_r[W][c]) << FRAC_BITS;
    end
    assign rem_d[0][c] = dvd0_r[c];
    assign q_d[0][c]   = '0;
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) vld_d_r[j+1] <= 1'b0;
      else        vld_d_r[j+1] <= vld_d_r[j];
      len_d_r[j+1] <= len_d_r[j];
      ok_d_r[j+1]  <= ok_d_r[j];
    end
    for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
      // quotient never passes 2^FRAC_BITS, so the top bit comes first
      vn_div_cell #(
        .IN_WIDTH  (IN_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .BIT       (FRAC_BITS - j)
      ) u_cell (
        .clk   (clk),
        .rem_i (rem_d[j][c]),
        .q_i   (q_d[j][c]),
        .len_i (len_d_r[j]),
        .rem_o (rem_d[j+1][c]),
        .q_o   (q_d[j+1][c])
      );
      always_ff @(posedge clk) begin
        neg_d_r[j+1][c] <= neg_d_r[j][c];
      end
    end
  end

  // output register
  logic          out_valid_r;
  logic          out_ok_r;
  logic [OW-1:0] unit_r [NUM_COMP];
  logic [OW-1:0] unit_nxt [NUM_COMP];

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_out
    always_comb begin
      if (!ok_d_r[ND]) begin
        unit_nxt[c] = '0;
      end else if (neg_d_r[ND][c]) begin
        unit_nxt[c] = OW'(0) - OW'(q_d[ND][c]);
      end else begin
        unit_nxt[c] = OW'(q_d[ND][c]);
      end
    end
    always_ff @(posedge clk) begin
      unit_r[c] <= unit_nxt[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= vld_d_r[ND];
    out_ok_r <= ok_d_r[ND];
  end

  assign out_valid  = out_valid_r;
  assign out_ok     = out_ok_r;
  assign out_unit_x = unit_r[0];
  assign out_unit_y = unit_r[1];
  assign out_unit_z = unit_r[2];

endmodule

// File: rtl/core/vn_sqrt_cell.sv
// ---------------------------------------------------------------------------
// vn_sqrt_cell
// One root bit of the digit-by-digit square root, registered.
// ---------------------------------------------------------------------------
module vn_sqrt_cell #(
  parameter int IN_WIDTH = 32
) (
  input  logic                  clk,
  input  logic [2*IN_WIDTH-1:0] rad_i,
  input  logic [IN_WIDTH:0]     rem_i,
  input  logic [IN_WIDTH-1:0]   root_i,
  output logic [2*IN_WIDTH-1:0] rad_o,
  output logic [IN_WIDTH:0]     rem_o,
  output logic [IN_WIDTH-1:0]   root_o
);
  localparam int SW = 2 * IN_WIDTH;
  localparam int RW = IN_WIDTH + 1;

  logic [SW-1:0]       rad_r, rad_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [IN_WIDTH-1:0] root_r, root_nxt;
  logic [RW+1:0]       trial;
  logic [RW+1:0]       tst;
  logic                ge;

  always_comb begin
    trial    = {rem_i, rad_i[SW-1:SW-2]};
    tst      = {1'b0, root_i, 2'b01};
    ge       = (trial >= tst);
    // remainder stays within 2*root, so the top bits drop out
    rem_nxt  = ge ? RW'(trial - tst) : RW'(trial);
    root_nxt = {root_i[IN_WIDTH-2:0], ge};
    rad_nxt  = {rad_i[SW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

// File: rtl/core/vn_div_cell.sv
// ---------------------------------------------------------------------------
// vn_div_cell
// One quotient bit of the restoring divide, registered.
// ---------------------------------------------------------------------------
module vn_div_cell #(
  parameter int IN_WIDTH  = 32,
  parameter int FRAC_BITS = 16,
  parameter int BIT       = 0
) (
  input  logic                          clk,
  input  logic [IN_WIDTH+FRAC_BITS-1:0] rem_i,
  input  logic [FRAC_BITS:0]            q_i,
  input  logic [IN_WIDTH-1:0]           len_i,
  output logic [IN_WIDTH+FRAC_BITS-1:0] rem_o,
  output logic [FRAC_BITS:0]            q_o
);
  localparam int DW = IN_WIDTH + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [DW-1:0] sh;
  logic          ge;

  always_comb begin
    sh      = DW'(len_i) << BIT;
    ge      = (rem_i >= sh);
    rem_nxt = ge ? (rem_i - sh) : rem_i;
    q_nxt   = q_i | (QW'(ge) << BIT);
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

// File: rtl/core/vn_checker.sv
// ---------------------------------------------------------------------------
// vn_checker
// Port-level checks on the vector normalizer, bound to the top level.
// ---------------------------------------------------------------------------
module vn_checker #(
  parameter int FRAC_BITS = 16,
  parameter int IN_WIDTH  = 32
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic signed [FRAC_BITS+1:0] out_unit_x,
  input logic signed [FRAC_BITS+1:0] out_unit_y,
  input logic signed [FRAC_BITS+1:0] out_unit_z,
  input logic                        out_ok
);
  localparam int LAT = IN_WIDTH + FRAC_BITS + 6;
  localparam logic signed [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

  // every accepted start transfer gives its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("missing result strobe");

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_not_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |->
      (out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0))
    else $error("nonzero result without ok");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ok) |->
      (out_unit_x <= ONE && out_unit_x >= -ONE &&
       out_unit_y <= ONE && out_unit_y >= -ONE &&
       out_unit_z <= ONE && out_unit_z >= -ONE))
    else $error("unit component out of range");

endmodule

bind vector3_normalize vn_checker #(
  .FRAC_BITS (FRAC_BITS),
  .IN_WIDTH  (IN_WIDTH)
) u_vn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_unit_x (out_unit_x),
  .out_unit_y (out_unit_y),
  .out_unit_z (out_unit_z),
  .out_ok     (out_ok)
);
